@@ hdl/positional_list_insert_delete_assert.svh @@
// Assertion macros for the positional list block.
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property at every clock edge outside reset.
`define PLID_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("positional list assertion failed");
// Check that the consequent holds in the cycle after the antecedent.
`define PLID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list assertion failed");
`else
`define PLID_ASSERT(lbl, prop)
`define PLID_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hdl/plid_pkg.sv @@
`timescale 1ns / 1ps
package plid_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_RIGHT = 2'd2,
        SEL_DIN   = 2'd3
    } cell_sel_t;

    typedef struct packed {
        cell_sel_t                 sel;
        logic signed [DATA_W-1:0]  din;
    } cell_ctl_t;

endpackage

@@ hdl/positional_list_insert_delete.sv @@
`timescale 1ns / 1ps
// Positional list of signed 32-bit values, addressed by 1-based position.
// Input channel (in_valid / in_stall) carries mode, position and value; the
// output channel (out_valid / out_stall) carries status, data and last.
// Insert shifts every entry at or above the position up by one cell, delete
// shifts the entries above it down; both finish in the cycle of the transfer
// and put their single result in the output register, shown in the next cycle.
// Insert and delete therefore run at one item per cycle while the receiver
// keeps up. Read-all rotates the first count cells through the head, one
// result per cycle after the transfer unless the output stalls, and leaves
// the list as it was; an empty list gives one empty result. No input is
// taken until its last result is loaded. Mode 3 is taken and produces nothing.
// A stalled result holds in the output register, and input is stalled as
// long as that register cannot be reloaded.
// Reset clears the entry count and the control state; cell contents are
// not cleared, since only entries below the count are ever read.
module positional_list_insert_delete #(
    parameter int CAPACITY = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         mode,
    input  logic [plid_pkg::POS_W-1:0]         position,
    input  logic signed [plid_pkg::DATA_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic signed [plid_pkg::DATA_W-1:0] data,
    output logic                               last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = plid_pkg::POS_W;
    localparam int DW = plid_pkg::DATA_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_cnt_reg, rd_cnt_next;
    logic               out_valid_reg, out_valid_next;
    plid_pkg::status_t  status_reg, status_next;
    logic signed [DW-1:0] data_reg, data_next;
    logic               last_reg, last_next;

    logic signed [DW-1:0] ent [CAPACITY];
    logic [PW-1:0]      cnt_p;
    logic               out_free;
    logic               take;
    logic               full;
    logic               ins_ok;
    logic               del_ok;
    logic               do_ins;
    logic               do_del;
    logic               do_rot;
    logic               rd_last;
    logic [IW-1:0]      del_idx;
    logic signed [DW-1:0] bcast;

    assign cnt_p    = PW'(count_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign take     = in_valid && !in_stall;
    assign full     = (count_reg == CW'(CAPACITY));

    assign ins_ok = (mode == plid_pkg::MODE_INSERT) && (position != '0)
                  && (position <= PW'(cnt_p + PW'(1))) && !full;
    assign del_ok = (mode == plid_pkg::MODE_DELETE) && (position != '0)
                  && (position <= cnt_p);

    assign do_ins  = take && ins_ok;
    assign do_del  = take && del_ok;
    assign do_rot  = (state_reg == ST_READ) && out_free;
    assign rd_last = (CW'(rd_cnt_reg + CW'(1)) == count_reg);
    assign del_idx = IW'(position - PW'(1));
    assign bcast   = do_rot ? ent[0] : value;

    // Cell row: each cell holds, takes a neighbor's word or loads the broadcast word.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [PW-1:0] CPOS = PW'(i + 1);
        plid_pkg::cell_ctl_t   ctl;
        logic signed [DW-1:0]  left_in;
        logic signed [DW-1:0]  right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_inner_l
            assign left_in = ent[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_top
            assign right_in = '0;
        end
        else
        begin : g_inner_r
            assign right_in = ent[i+1];
        end

        always_comb
        begin
            ctl.din = bcast;
            priority if (do_ins && (CPOS > position))
                ctl.sel = plid_pkg::SEL_LEFT;
            else if (do_ins && (CPOS == position))
                ctl.sel = plid_pkg::SEL_DIN;
            else if (do_del && (CPOS >= position))
                ctl.sel = plid_pkg::SEL_RIGHT;
            else if (do_rot && (CPOS == cnt_p))
                ctl.sel = plid_pkg::SEL_DIN;
            else if (do_rot && (CPOS < cnt_p))
                ctl.sel = plid_pkg::SEL_RIGHT;
            else
                ctl.sel = plid_pkg::SEL_HOLD;
        end

        plid_cell u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .left  (left_in),
            .right (right_in),
            .q     (ent[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_cnt_next    = rd_cnt_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        last_next      = last_reg;

        // Drop the current result once it has been taken.
        if (out_free)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    unique case (mode)
                        plid_pkg::MODE_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            data_next      = '0;
                            last_next      = 1'b1;
                            if ((position == '0) || (position > PW'(cnt_p + PW'(1))))
                                status_next = plid_pkg::STATUS_RANGE;
                            else if (full)
                                status_next = plid_pkg::STATUS_FULL;
                            else
                            begin
                                status_next = plid_pkg::STATUS_OK;
                                count_next  = CW'(count_reg + CW'(1));
                            end
                        end
                        plid_pkg::MODE_DELETE:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            if (del_ok)
                            begin
                                status_next = plid_pkg::STATUS_OK;
                                data_next   = ent[del_idx];
                                count_next  = CW'(count_reg - CW'(1));
                            end
                            else
                            begin
                                status_next = plid_pkg::STATUS_RANGE;
                                data_next   = '0;
                            end
                        end
                        plid_pkg::MODE_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = plid_pkg::STATUS_EMPTY;
                                data_next      = '0;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                rd_cnt_next = '0;
                                state_next  = ST_READ;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Advance the rotation only when the output register is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = plid_pkg::STATUS_OK;
                    data_next      = ent[0];
                    last_next      = rd_last;
                    rd_cnt_next    = CW'(rd_cnt_reg + CW'(1));
                    if (rd_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_cnt_reg    <= rd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign last      = last_reg;

`include "positional_list_insert_delete_assert.svh"

    `PLID_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY))
    `PLID_ASSERT(a_read_blocks_input, (state_reg == ST_READ) |-> in_stall)
    `PLID_ASSERT_NEXT(a_insert_grows, do_ins, count_reg == CW'($past(count_reg) + CW'(1)))
    `PLID_ASSERT_NEXT(a_read_ends_idle, do_rot && rd_last, state_reg == ST_IDLE && last_reg)

endmodule

@@ hdl/plid_cell.sv @@
`timescale 1ns / 1ps
module plid_cell (
    input  logic                               clk,
    input  plid_pkg::cell_ctl_t                ctl,
    input  logic signed [plid_pkg::DATA_W-1:0] left,
    input  logic signed [plid_pkg::DATA_W-1:0] right,
    output logic signed [plid_pkg::DATA_W-1:0] q
);

    logic signed [plid_pkg::DATA_W-1:0] entry_reg;
    logic signed [plid_pkg::DATA_W-1:0] entry_next;

    always_comb
    begin
        unique case (ctl.sel)
            plid_pkg::SEL_HOLD:  entry_next = entry_reg;
            plid_pkg::SEL_LEFT:  entry_next = left;
            plid_pkg::SEL_RIGHT: entry_next = right;
            plid_pkg::SEL_DIN:   entry_next = ctl.din;
            default:             entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import plid_pkg::*;

    localparam int DEPTH     = 32;
    localparam int DOG_LIMIT = 3000;
    localparam int ITEMS     = 420;
    localparam int CALM_FROM = 360;

    typedef struct packed {
        status_t                 st;
        logic signed [DATA_W-1:0] d;
        logic                    l;
    } list_result_t;

    // Shadow copy of the list and the results it owes.
    class list_scoreboard;
        logic signed [DATA_W-1:0] cells [DEPTH];
        int unsigned              held;
        list_result_t             due_results [$];
        int                       errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function void owe(status_t st, logic signed [DATA_W-1:0] d, logic l);
            list_result_t r;
            r.st = st;
            r.d  = d;
            r.l  = l;
            due_results.push_back(r);
        endfunction

        function void note_input(mode_t m, logic [POS_W-1:0] pos,
                                 logic signed [DATA_W-1:0] val);
            int unsigned p;
            p = pos;
            case (m)
                MODE_INSERT:
                begin
                    if (p < 1 || p > held + 1)
                        owe(STATUS_RANGE, '0, 1'b1);
                    else if (held >= DEPTH)
                        owe(STATUS_FULL, '0, 1'b1);
                    else
                    begin
                        for (int k = held; k >= p; k--)
                            cells[k] = cells[k-1];
                        cells[p-1] = val;
                        held++;
                        owe(STATUS_OK, '0, 1'b1);
                    end
                end
                MODE_DELETE:
                begin
                    if (p < 1 || p > held)
                        owe(STATUS_RANGE, '0, 1'b1);
                    else
                    begin
                        owe(STATUS_OK, cells[p-1], 1'b1);
                        for (int k = p; k < held; k++)
                            cells[k-1] = cells[k];
                        held--;
                    end
                end
                MODE_READ:
                begin
                    if (held == 0)
                        owe(STATUS_EMPTY, '0, 1'b1);
                    else
                        for (int k = 0; k < held; k++)
                            owe(STATUS_OK, cells[k], (k + 1 == held));
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] d, logic l);
            list_result_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d data %0d last %0b",
                         $time, st, d, l);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (st !== want.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.st, st);
                errors++;
            end
            if (d !== want.d)
            begin
                $display("%0t: data expected %0d actual %0d", $time, want.d, d);
                errors++;
            end
            if (l !== want.l)
            begin
                $display("%0t: last expected %0b actual %0b", $time, want.l, l);
                errors++;
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                mode;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [1:0]                status;
    logic signed [DATA_W-1:0]  data;
    logic                      last;

    list_scoreboard sb;
    int  idle_cycles = 0;
    int  issued = 0;
    int  gap_pct = 0;
    int  stall_pct = 0;
    int  stall_left = 0;
    int  stall_age = 0;
    bit  calm = 1'b0;

    positional_list_insert_delete dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .last      (last)
    );

    always #10 clk = ~clk;

    // Receiver: stall in bursts, with the burst rate changing now and then.
    always @(posedge clk)
    begin
        stall_age++;
        if (stall_age >= 50)
        begin
            stall_age = 0;
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 10;
                2: stall_pct = 30;
                default: stall_pct = 60;
            endcase
        end
        if (calm)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, data, last);
        if ((rst_n && out_valid && !out_stall) || (in_valid && !in_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial
    begin
        while (idle_cycles < DOG_LIMIT)
            @(posedge clk);
        $display("** positional_list_insert_delete: FAILED **");
        $finish;
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(mode_t m, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
        int gap;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        position <= pos;
        value    <= val;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(m, pos, val);
        if (m != MODE_NONE)
            issued++;
    endtask

    task automatic fill_list();
        while (sb.held < DEPTH)
            send_op(MODE_INSERT, POS_W'($urandom_range(1, sb.held + 1)), pick_value());
        // full list: valid position reports full, beyond the end reports range
        send_op(MODE_INSERT, POS_W'($urandom_range(1, DEPTH + 1)), pick_value());
        send_op(MODE_INSERT, POS_W'($urandom_range(DEPTH + 2, 127)), pick_value());
        send_op(MODE_READ, POS_W'($urandom), $urandom);
    endtask

    task automatic drain_list();
        while (sb.held > 0)
            send_op(MODE_DELETE, POS_W'($urandom_range(1, sb.held)), $urandom);
        send_op(MODE_DELETE, POS_W'($urandom_range(0, 127)), $urandom);
        send_op(MODE_READ, POS_W'($urandom), $urandom);
    endtask

    task automatic mixed_ops(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_op(MODE_INSERT, POS_W'($urandom_range(1, sb.held + 1)), pick_value());
            else if (r < 70)
                send_op(MODE_DELETE,
                        POS_W'(sb.held > 0 ? $urandom_range(1, sb.held)
                                           : $urandom_range(0, 127)),
                        $urandom);
            else if (r < 78)
                send_op(MODE_READ, POS_W'($urandom), $urandom);
            else if (r < 90)
                send_op(r[0] ? MODE_INSERT : MODE_DELETE, POS_W'($urandom_range(0, 127)),
                        pick_value());
            else if (r < 95)
                send_op(MODE_NONE, POS_W'($urandom), $urandom);
            else
                send_op(mode_t'($urandom_range(0, 3)), POS_W'($urandom), $urandom);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        mode     = MODE_INSERT;
        position = '0;
        value    = '0;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, bad positions, extremes, every operation
        send_op(MODE_READ,   7'd0,   32'd0);
        send_op(MODE_DELETE, 7'd1,   32'd0);
        send_op(MODE_INSERT, 7'd0,   32'd5);
        send_op(MODE_INSERT, 7'd2,   32'd5);
        send_op(MODE_INSERT, 7'd1,   32'h7FFF_FFFF);
        send_op(MODE_INSERT, 7'd1,   32'h8000_0000);
        send_op(MODE_INSERT, 7'd3,   32'hFFFF_FFFF);
        send_op(MODE_INSERT, 7'd127, 32'd1);
        send_op(MODE_DELETE, 7'd0,   32'd0);
        send_op(MODE_DELETE, 7'd4,   32'd0);
        send_op(MODE_READ,   7'd127, 32'hFFFF_FFFF);
        send_op(MODE_NONE,   7'd127, 32'hFFFF_FFFF);
        send_op(MODE_DELETE, 7'd2,   32'd0);
        send_op(MODE_DELETE, 7'd127, 32'd0);
        send_op(MODE_INSERT, 7'd2,   32'd0);
        send_op(MODE_READ,   7'd0,   32'd0);
        send_op(MODE_DELETE, 7'd3,   32'hFFFF_FFFF);
        send_op(MODE_DELETE, 7'd1,   32'd0);
        send_op(MODE_DELETE, 7'd1,   32'd0);
        send_op(MODE_READ,   7'd0,   32'd0);

        fill_list();
        while (issued < ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: gap_pct = 0;
                1: gap_pct = 10;
                2: gap_pct = 30;
                default: gap_pct = 60;
            endcase
            if (issued >= CALM_FROM)
                calm = 1'b1;
            case ($urandom_range(0, 5))
                0: fill_list();
                1: drain_list();
                default: mixed_ops(16);
            endcase
        end
        in_valid <= 1'b0;
        calm = 1'b1;

        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("** positional_list_insert_delete: PASSED **");
        else
            $display("** positional_list_insert_delete: FAILED **");
        $finish;
    end
endmodule
